>>> hw/rtl/pattern_run_length_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef PATTERN_RUN_LENGTH_DECODER_ASSERT_SVH
`define PATTERN_RUN_LENGTH_DECODER_ASSERT_SVH

// Property checked on every rising aclk edge outside reset.
`define PRLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define PRLD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

>>> hw/rtl/prld_pkg.sv
// Shared constants and types of the pattern run-length decoder.
package prld_pkg;

    localparam int PATTERN_MAX = 4;
    localparam int MAX_REPEATS = 64;
    localparam int OUT_BYTES   = 4;
    localparam int LEN_LIMIT   = (PATTERN_MAX < OUT_BYTES) ? PATTERN_MAX : OUT_BYTES;
    localparam int RUN_LIMIT   = (MAX_REPEATS * 4 < 255) ? MAX_REPEATS * 4 : 255;

    localparam int TOKEN_W     = 17;
    localparam int MAG_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 8;
    localparam int LEN_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [TOKEN_W-1:0] TOK_PATTERN = -17'sd2;
    localparam logic signed [TOKEN_W-1:0] TOK_RUN     = -17'sd1;

    typedef enum logic {
        MODE_PATTERN,
        MODE_RUN
    } mode_t;

    // One expansion job: pattern runs and literals repeat the whole
    // pattern, simple runs pack count bytes four to a beat.
    typedef struct packed {
        mode_t                                mode;
        logic [OUT_BYTES-1:0][BYTE_W-1:0]     bytes;
        logic [LEN_W-1:0]                     len;
        logic [CNT_W-1:0]                     count;
        logic                                 clamp;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> hw/rtl/prld_front.sv
// Token parser: tracks the marker phases and issues expansion jobs.
`include "pattern_run_length_decoder_assert.svh"

module prld_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [prld_pkg::TOKEN_W-1:0]  s_token,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 q_full,
    output logic                                 push,
    output prld_pkg::cmd_t                       push_cmd
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PLEN,
        PH_PREP,
        PH_PBYTES,
        PH_RVAL,
        PH_RCNT
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic [prld_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [prld_pkg::CNT_W-1:0]        rep_reg, rep_next;
    logic [prld_pkg::BYTE_W-1:0]       value_reg, value_next;
    logic [prld_pkg::LEN_W-1:0]        fill_reg, fill_next;
    logic                              clamp_reg, clamp_next;
    logic [prld_pkg::OUT_BYTES-1:0][prld_pkg::BYTE_W-1:0] store_reg;

    logic                              accept;
    logic [prld_pkg::MAG_W-1:0]        mag;
    logic [prld_pkg::BYTE_W-1:0]       tok_byte;
    logic                              len_over, rep_over, run_over;
    logic [prld_pkg::LEN_W-1:0]        fill_inc;
    logic [prld_pkg::CNT_W-1:0]        run_cnt;
    logic [prld_pkg::OUT_BYTES-1:0][prld_pkg::BYTE_W-1:0] pat_bytes;

    assign s_ready  = !q_full;
    assign accept   = s_valid && !q_full;
    // negative lengths and counts read as zero
    assign mag      = s_token[prld_pkg::TOKEN_W-1] ? '0 : s_token[prld_pkg::MAG_W-1:0];
    assign tok_byte = s_token[prld_pkg::BYTE_W-1:0];
    assign len_over = mag > prld_pkg::MAG_W'(prld_pkg::LEN_LIMIT);
    assign rep_over = mag > prld_pkg::MAG_W'(prld_pkg::MAX_REPEATS);
    assign run_over = mag > prld_pkg::MAG_W'(prld_pkg::RUN_LIMIT);
    assign fill_inc = fill_reg + prld_pkg::LEN_W'(1);
    assign run_cnt  = run_over ? prld_pkg::CNT_W'(prld_pkg::RUN_LIMIT)
                               : mag[prld_pkg::CNT_W-1:0];

    // pattern as it stands once the current byte lands, unused lanes zeroed
    always_comb begin
        for (int j = 0; j < prld_pkg::OUT_BYTES; j++) begin
            if (prld_pkg::LEN_W'(j) >= len_reg) begin
                pat_bytes[j] = '0;
            end else if (2'(j) == fill_reg[1:0]) begin
                pat_bytes[j] = tok_byte;
            end else begin
                pat_bytes[j] = store_reg[j];
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        rep_next   = rep_reg;
        value_next = value_reg;
        fill_next  = fill_reg;
        clamp_next = clamp_reg;
        push       = 1'b0;
        push_cmd   = '0;
        if (accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    priority if (s_token == prld_pkg::TOK_PATTERN) begin
                        clamp_next = 1'b0;
                        phase_next = PH_PLEN;
                    end else if (s_token == prld_pkg::TOK_RUN) begin
                        clamp_next = 1'b0;
                        phase_next = PH_RVAL;
                    end else begin
                        // literal: one-byte pattern, one repeat
                        push             = 1'b1;
                        push_cmd.mode    = prld_pkg::MODE_PATTERN;
                        push_cmd.bytes[0] = tok_byte;
                        push_cmd.len     = prld_pkg::LEN_W'(1);
                        push_cmd.count   = prld_pkg::CNT_W'(1);
                        push_cmd.clamp   = 1'b0;
                    end
                end
                PH_PLEN: begin
                    len_next   = len_over ? prld_pkg::LEN_W'(prld_pkg::LEN_LIMIT)
                                          : mag[prld_pkg::LEN_W-1:0];
                    clamp_next = clamp_reg | len_over;
                    phase_next = PH_PREP;
                end
                PH_PREP: begin
                    rep_next  = rep_over ? prld_pkg::CNT_W'(prld_pkg::MAX_REPEATS)
                                         : mag[prld_pkg::CNT_W-1:0];
                    fill_next = '0;
                    if (len_reg == '0) begin
                        clamp_next = 1'b0;
                        phase_next = PH_IDLE;
                    end else begin
                        clamp_next = clamp_reg | rep_over;
                        phase_next = PH_PBYTES;
                    end
                end
                PH_PBYTES: begin
                    fill_next = fill_inc;
                    if (fill_inc >= len_reg) begin
                        push           = (rep_reg != '0);
                        push_cmd.mode  = prld_pkg::MODE_PATTERN;
                        push_cmd.bytes = pat_bytes;
                        push_cmd.len   = len_reg;
                        push_cmd.count = rep_reg;
                        push_cmd.clamp = clamp_reg;
                        clamp_next     = 1'b0;
                        phase_next     = PH_IDLE;
                    end
                end
                PH_RVAL: begin
                    value_next = tok_byte;
                    phase_next = PH_RCNT;
                end
                PH_RCNT: begin
                    push           = (run_cnt != '0);
                    push_cmd.mode  = prld_pkg::MODE_RUN;
                    push_cmd.bytes = {prld_pkg::OUT_BYTES{value_reg}};
                    push_cmd.len   = prld_pkg::LEN_W'(prld_pkg::OUT_BYTES);
                    push_cmd.count = run_cnt;
                    push_cmd.clamp = clamp_reg | run_over;
                    clamp_next     = 1'b0;
                    phase_next     = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            rep_reg   <= '0;
            value_reg <= '0;
            fill_reg  <= '0;
            clamp_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            rep_reg   <= rep_next;
            value_reg <= value_next;
            fill_reg  <= fill_next;
            clamp_reg <= clamp_next;
        end
    end

    // pattern bytes, no reset: only lanes written in this run are read
    always_ff @(posedge aclk) begin
        if (accept && phase_reg == PH_PBYTES) begin
            store_reg[fill_reg[1:0]] <= tok_byte;
        end
    end

    `PRLD_ASSERT(a_fill_in_range, (phase_reg == PH_PBYTES) |-> (len_reg != '0 && fill_reg < len_reg), "pattern fill out of range")

endmodule

>>> hw/rtl/prld_queue.sv
// Small job queue between parser and expander.
`include "pattern_run_length_decoder_assert.svh"

module prld_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  prld_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output prld_pkg::cmd_t        head,
    output prld_pkg::q_status_t   status
);

    localparam int PTR_W = $clog2(prld_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(prld_pkg::QUEUE_DEPTH + 1);

    prld_pkg::cmd_t      mem [prld_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(prld_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign status.full  = (count_reg == CNT_W'(prld_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `PRLD_NEVER(a_push_when_full, push && status.full, "job pushed into full queue")
    `PRLD_NEVER(a_pop_when_empty, pop && status.empty, "job popped from empty queue")

endmodule

>>> hw/rtl/prld_back.sv
// Run expander: turns jobs into result beats behind an output register.
`include "pattern_run_length_decoder_assert.svh"

module prld_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  prld_pkg::cmd_t                    head,
    input  logic                              q_empty,
    output logic                              pop,
    output logic [prld_pkg::BYTE_W-1:0]       m_byte0,
    output logic [prld_pkg::BYTE_W-1:0]       m_byte1,
    output logic [prld_pkg::BYTE_W-1:0]       m_byte2,
    output logic [prld_pkg::BYTE_W-1:0]       m_byte3,
    output logic [prld_pkg::LEN_W-1:0]        m_byte_count,
    output logic                              m_last_of_run,
    output logic                              m_clamp_flag,
    output logic                              m_valid,
    input  logic                              m_ready
);

    prld_pkg::cmd_t                 cur_reg;
    logic                           active_reg;
    logic [prld_pkg::CNT_W-1:0]     left_reg;
    logic                           m_valid_reg;
    logic [prld_pkg::OUT_BYTES-1:0][prld_pkg::BYTE_W-1:0] bytes_reg;
    logic [prld_pkg::LEN_W-1:0]     count_reg;
    logic                           last_reg;
    logic                           clamp_reg;

    prld_pkg::cmd_t                 src;
    logic [prld_pkg::CNT_W-1:0]     left_src;
    logic [prld_pkg::CNT_W-1:0]     step;
    logic [prld_pkg::CNT_W-1:0]     left_next;
    logic [prld_pkg::LEN_W-1:0]     beat_cnt;
    logic [prld_pkg::OUT_BYTES-1:0][prld_pkg::BYTE_W-1:0] beat_bytes;
    logic                           fire;

    // a fresh job at the queue head issues its first beat straight away
    assign src      = active_reg ? cur_reg : head;
    assign left_src = active_reg ? left_reg : head.count;
    assign fire     = (active_reg || !q_empty) && (!m_valid_reg || m_ready);
    assign pop      = fire && !active_reg;

    always_comb begin
        if (src.mode == prld_pkg::MODE_PATTERN) begin
            beat_cnt = src.len;
            step     = prld_pkg::CNT_W'(1);
        end else begin
            beat_cnt = (left_src >= prld_pkg::CNT_W'(prld_pkg::OUT_BYTES))
                       ? prld_pkg::LEN_W'(prld_pkg::OUT_BYTES)
                       : left_src[prld_pkg::LEN_W-1:0];
            step     = prld_pkg::CNT_W'(beat_cnt);
        end
        left_next = left_src - step;
        for (int j = 0; j < prld_pkg::OUT_BYTES; j++) begin
            beat_bytes[j] = (prld_pkg::LEN_W'(j) < beat_cnt) ? src.bytes[j] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            active_reg  <= 1'b0;
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
                bytes_reg   <= beat_bytes;
                count_reg   <= beat_cnt;
                last_reg    <= (left_next == '0);
                clamp_reg   <= !active_reg && src.clamp;
                left_reg    <= left_next;
                active_reg  <= (left_next != '0);
                if (!active_reg) begin
                    cur_reg <= head;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_byte0       = bytes_reg[0];
    assign m_byte1       = bytes_reg[1];
    assign m_byte2       = bytes_reg[2];
    assign m_byte3       = bytes_reg[3];
    assign m_byte_count  = count_reg;
    assign m_last_of_run = last_reg;
    assign m_clamp_flag  = clamp_reg;

    `PRLD_ASSERT(a_active_has_work, active_reg |-> (left_reg != '0), "active job with nothing left")
    `PRLD_ASSERT(a_beat_count_range, m_valid_reg |-> (count_reg != '0 && count_reg <= prld_pkg::LEN_W'(prld_pkg::OUT_BYTES)), "beat byte count out of range")

endmodule

>>> hw/rtl/pattern_run_length_decoder.sv
// Pattern run-length decoder top level: parser, job queue, expander.
//
// Decodes a stream of 17-bit signed tokens into beats of up to four bytes.
// In the idle phase -2 opens a pattern run (length, repeat count, pattern
// bytes follow), -1 opens a simple run (value, count follow), anything else
// is a literal byte that yields one beat. A pattern run yields one beat per
// repeat carrying the whole pattern; a simple run packs its bytes four to a
// beat. Lengths above 4, repeats above 64 and run counts above 255 are
// clamped and flagged on the first beat; runs that yield nothing drop the
// flag.
// Rate: the parser takes one token per cycle, as long as the two-entry job
// queue has room. Marker, length, count and pattern-byte tokens produce no
// beat of their own. The expander issues one beat per cycle while m_ready
// does not hold it, so a literal stream runs at one token per cycle and a
// run keeps the expander busy until its last beat; the input stalls once two
// jobs wait behind it. Output beats sit in a register, so a stalled m_ready
// never blocks the parser directly; a token's job is written into the job
// queue, and its first beat is then held in the output register.
module pattern_run_length_decoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [prld_pkg::TOKEN_W-1:0]  s_token,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    output logic [prld_pkg::BYTE_W-1:0]          m_byte0,
    output logic [prld_pkg::BYTE_W-1:0]          m_byte1,
    output logic [prld_pkg::BYTE_W-1:0]          m_byte2,
    output logic [prld_pkg::BYTE_W-1:0]          m_byte3,
    output logic [prld_pkg::LEN_W-1:0]           m_byte_count,
    output logic                                 m_last_of_run,
    output logic                                 m_clamp_flag,
    output logic                                 m_valid,
    input  logic                                 m_ready
);

    logic                  push;
    logic                  pop;
    prld_pkg::cmd_t        push_cmd;
    prld_pkg::cmd_t        head;
    prld_pkg::q_status_t   q_status;

    // parser: phase tracking, clamping, pattern capture
    prld_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_token  (s_token),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .q_full   (q_status.full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decouples token intake from beat expansion
    prld_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // expander with the output register
    prld_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .q_empty       (q_status.empty),
        .pop           (pop),
        .m_byte0       (m_byte0),
        .m_byte1       (m_byte1),
        .m_byte2       (m_byte2),
        .m_byte3       (m_byte3),
        .m_byte_count  (m_byte_count),
        .m_last_of_run (m_last_of_run),
        .m_clamp_flag  (m_clamp_flag),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule
